// File: rtl/pixel_replication_upscaler_unit_assert.svh
`ifndef PIXEL_REPLICATION_UPSCALER_UNIT_ASSERT_SVH
`define PIXEL_REPLICATION_UPSCALER_UNIT_ASSERT_SVH

// check a condition on every clock edge out of reset
`define PRU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// check that a trigger implies a consequence in the same cycle
`define PRU_ASSERT_IMPLY(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

`endif

// File: rtl/pru_pkg.sv
package pru_pkg;

  localparam int MAX_ROW_PIXELS = 1024;
  localparam int ADDR_W = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;
  localparam int CNT_W = ADDR_W + 1;
  localparam int SCALE_MAX = 100;
  localparam int PIXEL_W = 24;
  localparam logic [7:0] PAD_BYTE = 8'h00;

  localparam logic CFG_SCALE_FACTOR = 1'b0;
  localparam logic CFG_ROW_PIXELS = 1'b1;

  typedef enum logic {
    PH_LOAD   = 1'b0,
    PH_REPLAY = 1'b1
  } phase_t;

  typedef struct packed {
    logic valid;
    logic out_valid;
    logic is_pad;
    logic use_store;
    logic row_end;
    logic group_end;
    logic rejected;
  } stage_t;

endpackage

// File: rtl/pixel_replication_upscaler_unit.sv
// Integer nearest-neighbor upscaler for rows of 24-bit pixels. Load requests
// (req_type 0) fill the row store with row_pixels pixels; replay requests
// (req_type 1) then return the upscaled row one element per request, each pixel
// repeated scale_factor times, each row repeated scale_factor times, and each
// output row padded with zero bytes to a multiple of four bytes. Every request,
// load or replay, gives exactly one result; a request of the wrong kind for the
// current phase comes back with rejected set. The block takes one request per
// clock unless result_stall holds the output; a request sits in the stage
// register, beside the registered row store read, then in the output register.
// Configuration writes are always ready and must be done between requests.
module pixel_replication_upscaler_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic        req_type,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  red_in,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        out_valid,
  output logic        is_pad,
  output logic [7:0]  blue_out,
  output logic [7:0]  green_out,
  output logic [7:0]  red_out,
  output logic        row_end,
  output logic        group_end,
  output logic        rejected
);

  logic                        accept, out_load;
  logic                        wr_en, rd_en;
  logic [pru_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
  logic [pru_pkg::PIXEL_W-1:0] wr_data, rd_data;
  pru_pkg::stage_t             stage;

  assign cfg_ready   = 1'b1;
  assign out_load    = stage.valid && (!result_valid || !result_stall);
  assign pixel_stall = stage.valid && !out_load;
  assign accept      = pixel_valid && !pixel_stall;

  pru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .accept   (accept),
    .advance  (out_load),
    .req_type (req_type),
    .blue_in  (blue_in),
    .green_in (green_in),
    .red_in   (red_in),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .stage    (stage)
  );

  pru_row_store u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_valid <= stage.out_valid;
      is_pad    <= stage.is_pad;
      row_end   <= stage.row_end;
      group_end <= stage.group_end;
      rejected  <= stage.rejected;
      blue_out  <= stage.use_store ? rd_data[7:0]   : pru_pkg::PAD_BYTE;
      green_out <= stage.use_store ? rd_data[15:8]  : pru_pkg::PAD_BYTE;
      red_out   <= stage.use_store ? rd_data[23:16] : pru_pkg::PAD_BYTE;
    end
  end

  `include "pixel_replication_upscaler_unit_assert.svh"

  `PRU_ASSERT_IMPLY(a_no_overrun, stage.valid && result_valid && result_stall, pixel_stall, "stage overrun")
  `PRU_ASSERT_IMPLY(a_reject_empty, result_valid && rejected, !out_valid && !row_end && !is_pad, "rejected result carries data")
  `PRU_ASSERT_IMPLY(a_group_row, result_valid && group_end, row_end && out_valid, "group end without row end")

endmodule

// File: rtl/pru_row_store.sv
module pru_row_store (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [pru_pkg::ADDR_W-1:0]   wr_addr,
  input  logic [pru_pkg::PIXEL_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [pru_pkg::ADDR_W-1:0]   rd_addr,
  output logic [pru_pkg::PIXEL_W-1:0]  rd_data
);

  logic [pru_pkg::PIXEL_W-1:0] mem [pru_pkg::MAX_ROW_PIXELS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/pru_ctrl.sv
module pru_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_index,
  input  logic [10:0]                  cfg_data,
  input  logic                         accept,
  input  logic                         advance,
  input  logic                         req_type,
  input  logic [7:0]                   blue_in,
  input  logic [7:0]                   green_in,
  input  logic [7:0]                   red_in,
  output logic                         wr_en,
  output logic [pru_pkg::ADDR_W-1:0]   wr_addr,
  output logic [pru_pkg::PIXEL_W-1:0]  wr_data,
  output logic                         rd_en,
  output logic [pru_pkg::ADDR_W-1:0]   rd_addr,
  output pru_pkg::stage_t              stage
);

  localparam int CW = pru_pkg::CNT_W;

  logic [6:0]                 scale_factor;
  logic [10:0]                row_pixels;
  pru_pkg::phase_t            phase, phase_next;
  logic [pru_pkg::ADDR_W-1:0] load_index, load_index_next;
  logic [pru_pkg::ADDR_W-1:0] read_index, read_index_next;
  logic [6:0]                 pixel_repeat, pixel_repeat_next;
  logic [6:0]                 row_repeat, row_repeat_next;
  logic [1:0]                 pad_left, pad_left_next;
  pru_pkg::stage_t            stage_new;

  logic [6:0]    s_eff;
  logic [CW-1:0] w_eff;
  logic [1:0]    pad_amt;
  logic          kind_ok, do_load, do_req;
  logic          pad_active, pad_done, last_rep, last_px, last_load, last_row, row_fin;

  always_comb begin
    if (scale_factor == 7'd0) begin
      s_eff = 7'd1;
    end else if (scale_factor > 7'(pru_pkg::SCALE_MAX)) begin
      s_eff = 7'(pru_pkg::SCALE_MAX);
    end else begin
      s_eff = scale_factor;
    end
    if (row_pixels == 11'd0) begin
      w_eff = CW'(1);
    end else if (32'(row_pixels) > 32'(pru_pkg::MAX_ROW_PIXELS)) begin
      w_eff = CW'(pru_pkg::MAX_ROW_PIXELS);
    end else begin
      w_eff = CW'(row_pixels);
    end
  end

  assign pad_amt    = 2'({2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]});
  assign kind_ok    = (req_type == (phase == pru_pkg::PH_REPLAY));
  assign do_load    = accept && kind_ok && !req_type;
  assign do_req     = accept && kind_ok && req_type;
  assign pad_active = (pad_left != 2'd0);
  assign pad_done   = (pad_left == 2'd1);
  assign last_rep   = ({1'b0, pixel_repeat} + 8'd1) >= {1'b0, s_eff};
  assign last_px    = last_rep && (({1'b0, read_index} + CW'(1)) >= w_eff);
  assign last_load  = ({1'b0, load_index} + CW'(1)) >= w_eff;
  assign last_row   = ({1'b0, row_repeat} + 8'd1) >= {1'b0, s_eff};
  assign row_fin    = do_req && (pad_active ? pad_done : (last_px && pad_amt == 2'd0));

  always_comb begin
    phase_next        = phase;
    load_index_next   = load_index;
    read_index_next   = read_index;
    pixel_repeat_next = pixel_repeat;
    row_repeat_next   = row_repeat;
    pad_left_next     = pad_left;
    if (do_load) begin
      if (last_load) begin
        phase_next        = pru_pkg::PH_REPLAY;
        load_index_next   = '0;
        read_index_next   = '0;
        pixel_repeat_next = '0;
        row_repeat_next   = '0;
        pad_left_next     = '0;
      end else begin
        load_index_next = load_index + 1'b1;
      end
    end
    if (do_req) begin
      if (pad_active) begin
        pad_left_next = pad_left - 2'd1;
      end else begin
        if (last_rep) begin
          pixel_repeat_next = '0;
          read_index_next   = read_index + 1'b1;
        end else begin
          pixel_repeat_next = pixel_repeat + 7'd1;
        end
        if (last_px) begin
          read_index_next   = '0;
          pixel_repeat_next = '0;
          pad_left_next     = pad_amt;
        end
      end
      if (row_fin) begin
        if (last_row) begin
          phase_next      = pru_pkg::PH_LOAD;
          load_index_next = '0;
          row_repeat_next = '0;
        end else begin
          row_repeat_next = row_repeat + 7'd1;
        end
      end
    end
  end

  always_comb begin
    stage_new           = '0;
    stage_new.valid     = 1'b1;
    stage_new.rejected  = !kind_ok;
    stage_new.out_valid = do_req;
    stage_new.is_pad    = do_req && pad_active;
    stage_new.use_store = do_req && !pad_active;
    stage_new.row_end   = row_fin;
    stage_new.group_end = row_fin && last_row;
    wr_en   = do_load;
    wr_addr = load_index;
    wr_data = {red_in, green_in, blue_in};
    rd_en   = do_req && !pad_active;
    rd_addr = read_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor <= 7'd1;
      row_pixels   <= 11'd1;
      phase        <= pru_pkg::PH_LOAD;
      load_index   <= '0;
      read_index   <= '0;
      pixel_repeat <= '0;
      row_repeat   <= '0;
      pad_left     <= '0;
      stage        <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          pru_pkg::CFG_SCALE_FACTOR: scale_factor <= cfg_data[6:0];
          pru_pkg::CFG_ROW_PIXELS:   row_pixels   <= cfg_data;
          default: ;
        endcase
      end
      phase        <= phase_next;
      load_index   <= load_index_next;
      read_index   <= read_index_next;
      pixel_repeat <= pixel_repeat_next;
      row_repeat   <= row_repeat_next;
      pad_left     <= pad_left_next;
      if (accept) begin
        stage <= stage_new;
      end else if (advance) begin
        stage.valid <= 1'b0;
      end
    end
  end

  `include "pixel_replication_upscaler_unit_assert.svh"

  `PRU_ASSERT_ALWAYS(a_pixel_repeat_range, pixel_repeat < 7'(pru_pkg::SCALE_MAX), "pixel repeat out of range")
  `PRU_ASSERT_ALWAYS(a_row_repeat_range, row_repeat < 7'(pru_pkg::SCALE_MAX), "row repeat out of range")
  `PRU_ASSERT_IMPLY(a_pad_in_replay, pad_left != 2'd0, phase == pru_pkg::PH_REPLAY, "padding outside replay")

endmodule

// File: tb/pixel_replication_upscaler_unit_tb.sv
`timescale 1ns / 100ps

module pixel_replication_upscaler_unit_tb;

  localparam int ITEM_TARGET = 1550;
  localparam int GROUP_CAP = 160;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SPECIAL_CNT = 2;

  typedef struct packed {
    logic       out_valid;
    logic       is_pad;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic       group_end;
    logic       rejected;
  } elem_t;

  typedef struct {
    bit              is_cfg;
    logic            cfg_idx;
    logic [10:0]     cfg_val;
    pru_pkg::phase_t kind;
    logic [7:0]      blue;
    logic [7:0]      green;
    logic [7:0]      red;
    bit              typed;
    elem_t           want;
  } plan_row_t;

  localparam elem_t NOTHING_ELEM = '0;
  localparam elem_t REJECT_ELEM = '{1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b1};
  localparam elem_t PAD_LAST_ELEM = '{1'b1, 1'b1, pru_pkg::PAD_BYTE, pru_pkg::PAD_BYTE,
                                      pru_pkg::PAD_BYTE, 1'b1, 1'b1, 1'b0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [10:0] cfg_data = '0;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  logic        req_type = 1'b0;
  logic [7:0]  blue_in = '0;
  logic [7:0]  green_in = '0;
  logic [7:0]  red_in = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        out_valid;
  logic        is_pad;
  logic [7:0]  blue_out;
  logic [7:0]  green_out;
  logic [7:0]  red_out;
  logic        row_end;
  logic        group_end;
  logic        rejected;

  pixel_replication_upscaler_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .req_type     (req_type),
    .blue_in      (blue_in),
    .green_in     (green_in),
    .red_in       (red_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_valid    (out_valid),
    .is_pad       (is_pad),
    .blue_out     (blue_out),
    .green_out    (green_out),
    .red_out      (red_out),
    .row_end      (row_end),
    .group_end    (group_end),
    .rejected     (rejected)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // upscaler state mirror
  logic [23:0]     row_mem [pru_pkg::MAX_ROW_PIXELS];
  pru_pkg::phase_t cur_phase = pru_pkg::PH_LOAD;
  logic [10:0]     fill_idx = '0;
  logic [9:0]      rd_idx = '0;
  logic [6:0]      px_rep = '0;
  logic [6:0]      line_rep = '0;
  logic [1:0]      pad_cnt = '0;
  logic [6:0]      cur_scale = 7'd1;
  logic [10:0]     cur_rows = 11'd1;
  int              filled_hwm = 0;

  elem_t pending_elems [$];
  elem_t oldest;
  int    fail_cnt = 0;
  int    sent_cnt = 0;
  int    cycle_cnt = 0;
  int    stall_left = 0;
  bit    calm = 1'b0;
  plan_row_t plan [$];

  initial begin
    foreach (row_mem[i]) row_mem[i] = '0;
  end

  function automatic elem_t upscale_predict(pru_pkg::phase_t kind, logic [7:0] b,
                                            logic [7:0] g, logic [7:0] r);
    elem_t e;
    int s, w, pad;
    bit last_rep, last_px, row_done;
    e = '0;
    row_done = 1'b0;
    s = (int'(cur_scale) < 1) ? 1 : (int'(cur_scale) > pru_pkg::SCALE_MAX)
      ? pru_pkg::SCALE_MAX : int'(cur_scale);
    w = (int'(cur_rows) < 1) ? 1 : (int'(cur_rows) > pru_pkg::MAX_ROW_PIXELS)
      ? pru_pkg::MAX_ROW_PIXELS : int'(cur_rows);
    if (kind != cur_phase) begin
      e.rejected = 1'b1;
      return e;
    end
    if (kind == pru_pkg::PH_LOAD) begin
      row_mem[fill_idx[9:0]] = {r, g, b};
      if (int'(fill_idx) + 1 > filled_hwm) filled_hwm = int'(fill_idx) + 1;
      if (int'(fill_idx) + 1 >= w) begin
        cur_phase = pru_pkg::PH_REPLAY;
        fill_idx = '0;
        rd_idx = '0;
        px_rep = '0;
        line_rep = '0;
        pad_cnt = '0;
      end else begin
        fill_idx++;
      end
      return e;
    end
    e.out_valid = 1'b1;
    if (pad_cnt != 0) begin
      e.is_pad = 1'b1;
      {e.red, e.green, e.blue} = {pru_pkg::PAD_BYTE, pru_pkg::PAD_BYTE, pru_pkg::PAD_BYTE};
      pad_cnt--;
      row_done = (pad_cnt == 0);
    end else begin
      last_rep = (int'(px_rep) + 1 >= s);
      last_px = last_rep && (int'(rd_idx) + 1 >= w);
      {e.red, e.green, e.blue} = row_mem[rd_idx];
      if (last_rep) begin
        px_rep = '0;
        rd_idx++;
      end else begin
        px_rep++;
      end
      if (last_px) begin
        pad = (4 - ((w * s * 3) & 3)) & 3;
        rd_idx = '0;
        px_rep = '0;
        if (pad > 0) pad_cnt = 2'(pad);
        else row_done = 1'b1;
      end
    end
    if (row_done) begin
      e.row_end = 1'b1;
      if (int'(line_rep) + 1 >= s) begin
        e.group_end = 1'b1;
        cur_phase = pru_pkg::PH_LOAD;
        fill_idx = '0;
        line_rep = '0;
      end else begin
        line_rep++;
      end
    end
    return e;
  endfunction

  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endfunction

  task automatic send_req(input pru_pkg::phase_t kind, input logic [7:0] b,
                          input logic [7:0] g, input logic [7:0] r, input bit typed,
                          input elem_t want, output elem_t pred);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    req_type <= kind;
    blue_in <= b;
    green_in <= g;
    red_in <= r;
    do @(posedge clk); while (pixel_stall);
    pred = upscale_predict(kind, b, g, r);
    pending_elems.push_back(typed ? want : pred);
    sent_cnt++;
  endtask

  // hold requests until every result is back
  task automatic drain_results();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending_elems.size() != 0);
  endtask

  task automatic write_reg(input logic idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == pru_pkg::CFG_SCALE_FACTOR) cur_scale = val[6:0];
    else cur_rows = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic plan_item(input pru_pkg::phase_t kind, input logic [7:0] b,
                           input logic [7:0] g, input logic [7:0] r, input bit typed,
                           input elem_t want);
    plan.push_back('{1'b0, pru_pkg::CFG_SCALE_FACTOR, 11'd0, kind, b, g, r, typed, want});
  endtask

  task automatic plan_cfg(input logic idx, input logic [10:0] val);
    plan.push_back('{1'b1, idx, val, pru_pkg::PH_LOAD, 8'h00, 8'h00, 8'h00, 1'b0,
                     NOTHING_ELEM});
  endtask

  // cut the group short after cap requests by shrinking both registers
  task automatic run_group(input int cap);
    elem_t pred;
    pru_pkg::phase_t kind;
    int lim;
    int sent_here;
    bit done;
    bit cut;
    done = 1'b0;
    cut = 1'b0;
    sent_here = 0;
    while (!done) begin
      if (!cut && sent_here >= cap) begin
        drain_results();
        write_reg(pru_pkg::CFG_SCALE_FACTOR, 11'd1);
        write_reg(pru_pkg::CFG_ROW_PIXELS, 11'd1);
        cut = 1'b1;
      end else if ($urandom_range(0, 199) == 0) begin
        drain_results();
        if ($urandom_range(0, 1) == 1) begin
          write_reg(pru_pkg::CFG_SCALE_FACTOR, 11'($urandom_range(1, 4)));
        end else begin
          lim = (filled_hwm < 12) ? filled_hwm : 12;
          if (lim < 1) lim = 1;
          write_reg(pru_pkg::CFG_ROW_PIXELS, 11'($urandom_range(1, lim)));
        end
      end
      kind = cur_phase;
      if ($urandom_range(0, 99) < 5) begin
        kind = (cur_phase == pru_pkg::PH_LOAD) ? pru_pkg::PH_REPLAY : pru_pkg::PH_LOAD;
      end
      send_req(kind, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, NOTHING_ELEM, pred);
      sent_here++;
      done = pred.group_end;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      result_stall <= 1'b1;
      stall_left--;
    end else begin
      result_stall <= 1'b0;
      stall_left = idle_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_elems.size() == 0) begin
        $error("result with no request pending");
        fail_cnt++;
      end else begin
        oldest = pending_elems.pop_front();
        check_field("out_valid", oldest.out_valid, out_valid);
        check_field("is_pad", oldest.is_pad, is_pad);
        check_field("blue_out", oldest.blue, blue_out);
        check_field("green_out", oldest.green, green_out);
        check_field("red_out", oldest.red, red_out);
        check_field("row_end", oldest.row_end, row_end);
        check_field("group_end", oldest.group_end, group_end);
        check_field("rejected", oldest.rejected, rejected);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    elem_t pred;
    logic [10:0] spec_scale [SPECIAL_CNT];
    logic [10:0] spec_rows [SPECIAL_CNT];
    int spec_cap [SPECIAL_CNT];
    int r;
    int left;

    spec_scale = '{11'h7FF, 11'd1};
    spec_rows = '{11'd1, 11'h7FF};
    spec_cap = '{120, 1120};

    plan_item(pru_pkg::PH_REPLAY, 8'h00, 8'h00, 8'h00, 1'b1, REJECT_ELEM);
    plan_item(pru_pkg::PH_LOAD, 8'hFF, 8'h00, 8'hFF, 1'b1, NOTHING_ELEM);
    plan_item(pru_pkg::PH_LOAD, 8'h12, 8'h34, 8'h56, 1'b1, REJECT_ELEM);
    plan_item(pru_pkg::PH_REPLAY, 8'hFF, 8'hFF, 8'hFF, 1'b1,
              '{1'b1, 1'b0, 8'hFF, 8'h00, 8'hFF, 1'b0, 1'b0, 1'b0});
    plan_item(pru_pkg::PH_REPLAY, 8'h00, 8'h00, 8'h00, 1'b1, PAD_LAST_ELEM);
    plan_item(pru_pkg::PH_LOAD, 8'h00, 8'hFF, 8'h00, 1'b1, NOTHING_ELEM);
    plan_item(pru_pkg::PH_REPLAY, 8'h00, 8'h00, 8'h00, 1'b1,
              '{1'b1, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0});
    plan_item(pru_pkg::PH_REPLAY, 8'hFF, 8'hFF, 8'hFF, 1'b1, PAD_LAST_ELEM);
    plan_cfg(pru_pkg::CFG_SCALE_FACTOR, 11'd2);
    plan_cfg(pru_pkg::CFG_ROW_PIXELS, 11'd2);
    plan_item(pru_pkg::PH_LOAD, 8'hAA, 8'h55, 8'h0F, 1'b0, NOTHING_ELEM);
    plan_item(pru_pkg::PH_LOAD, 8'hF0, 8'hC3, 8'h3C, 1'b0, NOTHING_ELEM);
    repeat (8) plan_item(pru_pkg::PH_REPLAY, 8'h00, 8'h00, 8'h00, 1'b0, NOTHING_ELEM);
    plan_cfg(pru_pkg::CFG_SCALE_FACTOR, 11'd0);
    plan_cfg(pru_pkg::CFG_ROW_PIXELS, 11'd0);
    plan_item(pru_pkg::PH_LOAD, 8'h80, 8'h01, 8'h7F, 1'b1, NOTHING_ELEM);
    plan_item(pru_pkg::PH_REPLAY, 8'h00, 8'h00, 8'h00, 1'b1,
              '{1'b1, 1'b0, 8'h80, 8'h01, 8'h7F, 1'b0, 1'b0, 1'b0});
    plan_item(pru_pkg::PH_REPLAY, 8'h00, 8'h00, 8'h00, 1'b1, PAD_LAST_ELEM);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_results();
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_req(plan[i].kind, plan[i].blue, plan[i].green, plan[i].red, plan[i].typed,
                 plan[i].want, pred);
      end
    end

    calm = 1'b1;
    for (int k = 0; k < SPECIAL_CNT; k++) begin
      drain_results();
      write_reg(pru_pkg::CFG_SCALE_FACTOR, spec_scale[k]);
      write_reg(pru_pkg::CFG_ROW_PIXELS, spec_rows[k]);
      run_group(spec_cap[k]);
    end

    while (sent_cnt < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
        r = $urandom_range(0, 99);
        write_reg(pru_pkg::CFG_SCALE_FACTOR, (r < 80) ? 11'($urandom_range(1, 4))
                                                      : 11'($urandom_range(0, 12)));
        r = $urandom_range(0, 99);
        write_reg(pru_pkg::CFG_ROW_PIXELS, (r < 80) ? 11'($urandom_range(1, 8))
                                          : (r < 95) ? 11'($urandom_range(9, 40)) : 11'd0);
      end
      calm = ($urandom_range(0, 4) == 0);
      left = ITEM_TARGET - sent_cnt;
      run_group((left < GROUP_CAP) ? left : GROUP_CAP);
    end

    calm = 1'b0;
    drain_results();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
